// ----- sv/dfsdt_pkg.sv -----
// dfsdt_pkg: shared types for the depth-first search timestamp block
// used by dfsdt_adj and dfs_discovery_finish_times; no dependencies
package dfsdt_pkg;

  // request codes on the input channel (code 3 is unused and does nothing)
  typedef enum logic [1:0] {
    CMD_ADD_EDGE = 2'd0,
    CMD_RUN      = 2'd1,
    CMD_CLEAR    = 2'd2
  } dfsdt_cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_ROOT,
    ST_SCAN,
    ST_POP,
    ST_EMIT_RD,
    ST_EMIT_LD
  } dfsdt_state_t;

  // strobes from the sequencer to the adjacency memory
  typedef struct packed {
    logic clr;
    logic rd;
    logic wr;
  } dfsdt_adj_ctl_t;

endpackage

// ----- sv/dfs_discovery_finish_times.sv -----
// Depth-first search with discovery and finish timestamps over a stored
// directed adjacency matrix of MAX_VERTICES rows. An add-edge request does a
// row read and then a row write back, a clear request empties the matrix,
// and a run request walks vertices 1..n (n = vertex_count, saturated to
// MAX_VERTICES) and then delivers n results in vertex order, the last one
// flagged. The walk checks each root candidate in turn and enters it if it
// is white, enters the lowest white neighbor of the top vertex, finishes a
// vertex with no white neighbor left and returns to its parent, all through
// the single adjacency read port feeding the lowest-index neighbor picker;
// emission then reads and loads each result in turn, waiting while the
// output register still holds a result the sink has not taken. The input
// channel is not ready while a run or an edge write is in progress; it opens
// again once the last result is loaded into the output register.
//
// dfs_discovery_finish_times: top level, sequencer, stack and timestamp stores
// depends on dfsdt_pkg, dfsdt_adj, dfsdt_pick
module dfs_discovery_finish_times #(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // input requests
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [6:0] in_from_vertex,
  input  logic [6:0] in_to_vertex,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_vertex,
  output logic [7:0] out_discover_time,
  output logic [7:0] out_finish_time,
  output logic       out_last,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_vertex_count
);
  import dfsdt_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);

  dfsdt_state_t state_r, state_nxt;

  logic [6:0]              vertex_count_r;
  logic [NW-1:0]           n_r;
  logic [MAX_VERTICES-1:0] white_r;
  logic [7:0]              time_r;
  logic [NW-1:0]           depth_r;
  logic [NW-1:0]           root_r;
  logic [VW-1:0]           top_r;
  logic [NW-1:0]           emit_idx_r;
  logic [VW-1:0]           edge_from_r;
  logic [VW-1:0]           edge_to_r;
  logic                    out_valid_r;
  logic [6:0]              out_vertex_r;
  logic [7:0]              out_discover_r;
  logic [7:0]              out_finish_r;
  logic                    out_last_r;

  logic [VW-1:0] stk_mem  [MAX_VERTICES];
  logic [7:0]    disc_mem [MAX_VERTICES];
  logic [7:0]    fin_mem  [MAX_VERTICES];
  logic [VW-1:0] stk_q_r;
  logic [7:0]    disc_q_r;
  logic [7:0]    fin_q_r;

  logic                    in_fire;
  dfsdt_cmd_t              cmd;
  logic                    edge_ok;
  logic [NW-1:0]           eff_n;
  logic [MAX_VERTICES-1:0] run_mask;
  logic [VW-1:0]           from_idx;
  logic [VW-1:0]           to_idx;
  logic [VW-1:0]           root_idx;
  logic                    root_done;
  logic                    root_push;
  logic [MAX_VERTICES-1:0] adj_row;
  logic [MAX_VERTICES-1:0] edge_bit;
  logic                    pick_any;
  logic [VW-1:0]           pick_idx;
  logic [7:0]              time_inc;
  logic                    emit_last;

  // sequencer strobes
  dfsdt_adj_ctl_t adj_ctl;
  logic [VW-1:0]  adj_rd_addr;
  logic           push;
  logic [VW-1:0]  push_idx;
  logic           pop;
  logic           stk_rd;
  logic           emit_rd;
  logic           emit_ld;

  // request decode
  assign in_fire  = in_valid && in_ready;
  assign cmd      = dfsdt_cmd_t'(in_command);
  assign edge_ok  = (in_from_vertex != 7'd0) && (int'(in_from_vertex) <= MAX_VERTICES) &&
                    (in_to_vertex != 7'd0) && (int'(in_to_vertex) <= MAX_VERTICES);
  assign from_idx = VW'(in_from_vertex - 7'd1);
  assign to_idx   = VW'(in_to_vertex - 7'd1);

  // vertex count saturated to the matrix size
  assign eff_n = (int'(vertex_count_r) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                       : NW'(vertex_count_r);

  // vertices taking part in the run start white
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      run_mask[i] = (NW'(i) < eff_n);
    end
  end

  assign root_idx  = VW'(root_r);
  assign root_done = (root_r == n_r);
  assign root_push = !root_done && white_r[root_idx];
  assign time_inc  = time_r + 8'd1;
  assign emit_last = ((emit_idx_r + NW'(1)) == n_r);

  always_comb begin
    edge_bit = '0;
    edge_bit[edge_to_r] = 1'b1;
  end

  // adjacency memory
  dfsdt_adj #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (adj_ctl),
    .rd_addr (adj_rd_addr),
    .wr_addr (edge_from_r),
    .wr_data (adj_row | edge_bit),
    .rd_row  (adj_row)
  );

  // lowest white neighbor of the vertex on top of the stack
  dfsdt_pick #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_pick (
    .cand (adj_row & white_r),
    .any  (pick_any),
    .idx  (pick_idx)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_ADD_EDGE: if (edge_ok) state_nxt = ST_EDGE_WR;
            CMD_RUN:      if (eff_n != '0) state_nxt = ST_ROOT;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EDGE_WR: state_nxt = ST_IDLE;
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = ST_EMIT_RD;
        end else if (root_push) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pick_any) begin
          state_nxt = ST_SCAN;
        end else if (depth_r == NW'(1)) begin
          state_nxt = ST_ROOT;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: state_nxt = ST_SCAN;
      ST_EMIT_RD: if (!out_valid_r) state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: state_nxt = emit_last ? ST_IDLE : ST_EMIT_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    adj_ctl     = '0;
    adj_rd_addr = from_idx;
    push        = 1'b0;
    push_idx    = pick_idx;
    pop         = 1'b0;
    stk_rd      = 1'b0;
    emit_rd     = 1'b0;
    emit_ld     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        adj_ctl.rd  = in_fire && (cmd == CMD_ADD_EDGE);
        adj_ctl.clr = in_fire && (cmd == CMD_CLEAR);
      end
      ST_EDGE_WR: adj_ctl.wr = 1'b1;
      ST_ROOT: begin
        push        = root_push;
        push_idx    = root_idx;
        adj_ctl.rd  = root_push;
        adj_rd_addr = root_idx;
      end
      ST_SCAN: begin
        push        = pick_any;
        adj_ctl.rd  = pick_any;
        adj_rd_addr = pick_idx;
        pop         = !pick_any;
        stk_rd      = !pick_any && (depth_r != NW'(1));
      end
      ST_POP: begin
        adj_ctl.rd  = 1'b1;
        adj_rd_addr = stk_q_r;
      end
      ST_EMIT_RD: emit_rd = !out_valid_r;
      ST_EMIT_LD: emit_ld = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      vertex_count_r <= 7'd1;
      out_valid_r    <= 1'b0;
      depth_r        <= '0;
      time_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        vertex_count_r <= cfg_vertex_count;
      end
      if (emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire && (cmd == CMD_RUN)) begin
        depth_r <= '0;
        time_r  <= '0;
      end else if (push) begin
        depth_r <= depth_r + NW'(1);
        time_r  <= time_inc;
      end else if (pop) begin
        depth_r <= depth_r - NW'(1);
        time_r  <= time_inc;
      end
    end
  end

  // walk and emit bookkeeping
  always_ff @(posedge clk) begin
    if (in_fire && (cmd == CMD_RUN)) begin
      n_r        <= eff_n;
      white_r    <= run_mask;
      root_r     <= '0;
      emit_idx_r <= '0;
    end
    if (in_fire && (cmd == CMD_ADD_EDGE)) begin
      edge_from_r <= from_idx;
      edge_to_r   <= to_idx;
    end
    if (state_r == ST_ROOT && !root_done && !root_push) begin
      root_r <= root_r + NW'(1);
    end
    if (push) begin
      white_r[push_idx] <= 1'b0;
      top_r             <= push_idx;
    end
    if (state_r == ST_POP) begin
      top_r <= stk_q_r;
    end
    if (emit_ld) begin
      out_vertex_r   <= 7'(emit_idx_r + NW'(1));
      out_discover_r <= disc_q_r;
      out_finish_r   <= fin_q_r;
      out_last_r     <= emit_last;
      emit_idx_r     <= emit_idx_r + NW'(1);
    end
  end

  // path stack
  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[VW'(depth_r)] <= push_idx;
    end
    if (stk_rd) begin
      stk_q_r <= stk_mem[VW'(depth_r - NW'(2))];
    end
  end

  // timestamp stores
  always_ff @(posedge clk) begin
    if (push) begin
      disc_mem[push_idx] <= time_inc;
    end
    if (pop) begin
      fin_mem[top_r] <= time_inc;
    end
    if (emit_rd) begin
      disc_q_r <= disc_mem[VW'(emit_idx_r)];
      fin_q_r  <= fin_mem[VW'(emit_idx_r)];
    end
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_vertex        = out_vertex_r;
  assign out_discover_time = out_discover_r;
  assign out_finish_time   = out_finish_r;
  assign out_last          = out_last_r;

  // the stack never holds more vertices than take part in the run
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_POP) |-> (depth_r != '0 && depth_r <= n_r))
    else $error("path stack depth out of range");

  // every vertex is entered and finished once, so the walk ends at time 2n
  a_time_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT && root_done) |-> (time_r == 8'({n_r, 1'b0}) && depth_r == '0))
    else $error("walk ended with wrong time count");

  // a loaded result is presented in the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ld |=> out_valid)
    else $error("loaded result not presented");

  // no new request is taken while the walk or emission is running
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("request taken while busy");

endmodule

// ----- sv/dfsdt_adj.sv -----
// dfsdt_adj: adjacency matrix memory, one row per source vertex
// row valid bits give an instant clear; depends on dfsdt_pkg
module dfsdt_adj #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  dfsdt_pkg::dfsdt_adj_ctl_t                    ctl,
  input  logic [((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)-1:0] rd_addr,
  input  logic [((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)-1:0] wr_addr,
  input  logic [MAX_VERTICES-1:0]                      wr_data,
  output logic [MAX_VERTICES-1:0]                      rd_row
);
  import dfsdt_pkg::*;

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_r;
  logic [MAX_VERTICES-1:0] rd_data_r;
  logic                    rd_ok_r;

  // row valid bits: cleared by reset and by a clear request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (ctl.clr) begin
      row_vld_r <= '0;
    end else if (ctl.wr) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  // row write
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered row read
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data_r <= mem[rd_addr];
      rd_ok_r   <= row_vld_r[rd_addr];
    end
  end

  // a row never written since the last clear reads as empty
  assign rd_row = rd_ok_r ? rd_data_r : '0;

endmodule

// ----- sv/dfsdt_pick.sv -----
// dfsdt_pick: lowest-index search over the candidate neighbor vector
// used by every neighbor scan step of the walk; no dependencies
module dfsdt_pick #(
  parameter int MAX_VERTICES = 64
) (
  input  logic [MAX_VERTICES-1:0]                                    cand,
  output logic                                                       any,
  output logic [((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)-1:0] idx
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  // priority encoder, lowest set bit wins
  always_comb begin
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = VW'(i);
      end
    end
  end

  assign any = |cand;

endmodule
